[rtl/core/pbpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpc_pkg
// shared types and constants of the playout pacing controller
// ----------------------------------------------------------------------------
package pbpc_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] CFG_FRAME_MODE = 2'd0;
	localparam logic [1:0] CFG_WARMUP     = 2'd1;
	localparam logic [1:0] CFG_LOW_WATER  = 2'd2;
	localparam logic [1:0] CFG_GRACE      = 2'd3;

	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 16;

	// action codes
	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_PLAY    = 2'd1;
	localparam logic [1:0] ACT_SILENCE = 2'd2;

	// frame sizes in bytes and default thresholds (forty and twenty frames)
	localparam logic [8:0]  FRAME_MULAW       = 9'd160;
	localparam logic [8:0]  FRAME_LINEAR      = 9'd320;
	localparam logic [15:0] WARMUP_MULAW      = 16'd6400;
	localparam logic [15:0] WARMUP_LINEAR     = 16'd12800;
	localparam logic [15:0] LOW_WATER_MULAW   = 16'd3200;
	localparam logic [15:0] LOW_WATER_LINEAR  = 16'd6400;

	localparam logic [8:0] STREAK_MAX = 9'd511;

	typedef struct packed {
		logic [15:0] fill_level;
		logic        closing;
	} in_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [8:0]  read_bytes;
		logic        started;
		logic        paused;
		logic        playing;
		logic [31:0] underrun_total;
		logic [15:0] peak_fill;
	} out_t;

	typedef struct packed {
		logic        frame_mode;
		logic [15:0] warmup_bytes;
		logic [15:0] low_water_bytes;
		logic [7:0]  grace_ticks;
	} cfg_t;

	// playback state apart from the peak level
	typedef struct packed {
		logic        active;
		logic [8:0]  streak;
		logic [31:0] underruns;
	} state_t;

endpackage

[rtl/core/pbpc_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpc_step
// next-state and result logic for one tick
// ----------------------------------------------------------------------------
module pbpc_step import pbpc_pkg::*; #(
	parameter int LEVEL_WIDTH = 16
) (
	input  cfg_t                   cfg,
	input  state_t                 state,
	input  logic [LEVEL_WIDTH-1:0] peak,
	input  in_t                    item,
	output state_t                 state_next,
	output logic [LEVEL_WIDTH-1:0] peak_next,
	output out_t                   result
);

	localparam int IW = (LEVEL_WIDTH < 16) ? LEVEL_WIDTH : 16;
	localparam int CW = (LEVEL_WIDTH > 16) ? LEVEL_WIDTH : 16;

	logic [LEVEL_WIDTH-1:0] level;
	logic [CW-1:0]          level_c;
	logic [8:0]             frame;
	logic [15:0]            warmup;
	logic [15:0]            low_water;
	logic [8:0]             streak0;
	logic [8:0]             streak_inc;
	logic                   start;
	logic                   live;
	logic [CW-1:0]          peak_c;

	assign level   = LEVEL_WIDTH'(item.fill_level[IW-1:0]);
	assign level_c = CW'(level);

	always_comb begin
		frame     = cfg.frame_mode ? FRAME_MULAW : FRAME_LINEAR;
		warmup    = (cfg.warmup_bytes != 16'd0) ? cfg.warmup_bytes :
			(cfg.frame_mode ? WARMUP_MULAW : WARMUP_LINEAR);
		low_water = (cfg.low_water_bytes != 16'd0) ? cfg.low_water_bytes :
			(cfg.frame_mode ? LOW_WATER_MULAW : LOW_WATER_LINEAR);

		start      = !state.active && (level_c >= CW'(warmup));
		live       = state.active || start;
		streak0    = start ? 9'd0 : state.streak;
		streak_inc = (streak0 != STREAK_MAX) ? streak0 + 9'd1 : streak0;

		state_next = state;
		result     = '0;

		if (live) begin
			state_next.active = 1'b1;
			if (level_c >= CW'(frame)) begin
				result.action     = ACT_PLAY;
				result.read_bytes = frame;
				state_next.streak = 9'd0;
			end else begin
				if (state.underruns != '1) begin
					state_next.underruns = state.underruns + 32'd1;
				end
				state_next.streak = streak_inc;
				if (streak_inc <= {1'b0, cfg.grace_ticks}) begin
					result.action = ACT_SILENCE;
				end else if (level_c < CW'(low_water)) begin
					// grace used up and the buffer is low: back to refill
					state_next.active = 1'b0;
					state_next.streak = 9'd0;
					result.paused     = 1'b1;
				end
			end
		end
		result.started = start;

		peak_next = (level > peak) ? level : peak;

		// a closing tick leaves everything as it was
		if (item.closing) begin
			state_next = state;
			peak_next  = peak;
			result     = '0;
		end

		peak_c                = CW'(peak_next);
		result.playing        = state_next.active;
		result.underrun_total = state_next.underruns;
		result.peak_fill      = peak_c[15:0];
	end

endmodule

[rtl/core/playout_buffer_pacing_control_core.sv]
`timescale 1ns / 1ps
// path: a transferred tick is held in the input register, then its result is
//   loaded into the result register, from which it transfers
// throughput: one tick per cycle while the result channel is not stalled;
//   the single-pass decision logic sets it
// reset: arst_n clears the cfg registers, playback state and both valid flags
// ----------------------------------------------------------------------------
// playout_buffer_pacing_control_core
// jitter buffer playout pacing: warmup, frame reads, silence on underrun,
// pause for refill, underrun count and peak fill tracking
// ----------------------------------------------------------------------------
module playout_buffer_pacing_control_core import pbpc_pkg::*; #(
	parameter int LEVEL_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration writes
	input  logic                       cfg_wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
	// tick channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  in_t                        in_data,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output out_t                       out_data
);

	cfg_t                   cfg_q;

	// input stage
	logic                   in_valid_s1;
	in_t                    in_data_s1;

	// playback state
	state_t                 state_q;
	logic [LEVEL_WIDTH-1:0] peak_q;

	// result register
	logic                   out_valid_q;
	out_t                   out_data_q;

	state_t                 state_next;
	logic [LEVEL_WIDTH-1:0] peak_next;
	out_t                   result;
	logic                   advance;

	// a tick moves from the input stage to the result register when the
	// result register is empty or its transfer completes this cycle
	assign advance  = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = in_valid_s1 && !advance;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FRAME_MODE: cfg_q.frame_mode      <= cfg_wdata[0];
				CFG_WARMUP:     cfg_q.warmup_bytes    <= cfg_wdata;
				CFG_LOW_WATER:  cfg_q.low_water_bytes <= cfg_wdata;
				CFG_GRACE:      cfg_q.grace_ticks     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// input stage: refilled whenever it is empty or drains this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			in_data_s1 <= in_data;
		end
	end

	pbpc_step #(
		.LEVEL_WIDTH (LEVEL_WIDTH)
	) u_step (
		.cfg        (cfg_q),
		.state      (state_q),
		.peak       (peak_q),
		.item       (in_data_s1),
		.state_next (state_next),
		.peak_next  (peak_next),
		.result     (result)
	);

	// state commits only when the tick's result is captured, so a stall
	// downstream never applies a tick twice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_next;
			peak_q      <= peak_next;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

endmodule

[rtl/core/pbpc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpc_port_props
// port-level checks on the result channel of the playout controller
// ----------------------------------------------------------------------------
module pbpc_port_props import pbpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// a stalled result holds until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// bytes are requested only with a frame read, and only a whole frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.action == ACT_PLAY) ?
			(out_data.read_bytes == FRAME_MULAW || out_data.read_bytes == FRAME_LINEAR) :
			(out_data.read_bytes == 9'd0))
		else $error("read size does not match action");

	// a pause leaves playback stopped and plays nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.paused |-> !out_data.playing && out_data.action == ACT_NONE)
		else $error("pause with playback still active");

	// frames are played only while playback is active
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.action == ACT_PLAY || out_data.action == ACT_SILENCE)
		|-> out_data.playing)
		else $error("frame played while not playing");

endmodule

bind playout_buffer_pacing_control_core pbpc_port_props u_pbpc_port_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

[tb/pbpc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbpc_checker
// watches the register port and both channels of the playout pacing
// controller, predicts the decision for every accepted tick and compares
// each accepted result with the oldest prediction
// ----------------------------------------------------------------------------
module pbpc_checker import pbpc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  in_t                        in_data,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  out_t                       out_data,
	output int                         fails,
	output int                         pending,
	output int                         ticks,
	output int                         starts,
	output int                         pauses,
	output int                         silences
);

	localparam int unsigned WARMUP_FRAMES    = 40;
	localparam int unsigned LOW_WATER_FRAMES = 20;

	// mirrored registers and playback state
	cfg_t        cfg;
	logic        active;
	logic [8:0]  streak;
	logic [31:0] underruns;
	logic [15:0] peak;

	out_t play_decisions[$];
	out_t want;
	out_t fresh;

	function automatic out_t pace_tick(input in_t t);
		out_t        r;
		int unsigned frame;
		int unsigned warm;
		int unsigned low_mark;
		int unsigned level;
		r = '0;
		level = 32'(t.fill_level);
		// a closing tick leaves everything as it is
		if (!t.closing) begin
			frame = 32'(cfg.frame_mode ? FRAME_MULAW : FRAME_LINEAR);
			warm = (cfg.warmup_bytes != 16'd0) ? 32'(cfg.warmup_bytes)
				: frame * WARMUP_FRAMES;
			low_mark = (cfg.low_water_bytes != 16'd0) ? 32'(cfg.low_water_bytes)
				: frame * LOW_WATER_FRAMES;
			if (!active && level >= warm) begin
				active = 1'b1;
				streak = '0;
				r.started = 1'b1;
			end
			if (active) begin
				if (level >= frame) begin
					r.action = ACT_PLAY;
					r.read_bytes = frame[8:0];
					streak = '0;
				end else begin
					if (underruns != '1)
						underruns = underruns + 32'd1;
					if (streak < STREAK_MAX)
						streak = streak + 9'd1;
					if (streak <= {1'b0, cfg.grace_ticks}) begin
						r.action = ACT_SILENCE;
					end else if (level < low_mark) begin
						active = 1'b0;
						streak = '0;
						r.paused = 1'b1;
					end
				end
			end
			if (t.fill_level > peak)
				peak = t.fill_level;
		end
		r.playing = active;
		r.underrun_total = underruns;
		r.peak_fill = peak;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t  %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '0;
			active = 1'b0;
			streak = '0;
			underruns = '0;
			peak = '0;
			play_decisions.delete();
			fails = 0;
			pending = 0;
			ticks = 0;
			starts = 0;
			pauses = 0;
			silences = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_FRAME_MODE: cfg.frame_mode = cfg_wdata[0];
					CFG_WARMUP:     cfg.warmup_bytes = cfg_wdata;
					CFG_LOW_WATER:  cfg.low_water_bytes = cfg_wdata;
					CFG_GRACE:      cfg.grace_ticks = cfg_wdata[7:0];
					default: ;
				endcase
			end
			// results first: a tick accepted now cannot have its result yet
			if (out_valid && !out_stall) begin
				if (play_decisions.size() == 0) begin
					$display("%0t  result with no tick waiting: %h", $time, out_data);
					fails++;
				end else begin
					want = play_decisions.pop_front();
					compare_field("action", 32'(want.action), 32'(out_data.action));
					compare_field("read_bytes", 32'(want.read_bytes),
						32'(out_data.read_bytes));
					compare_field("started", 32'(want.started), 32'(out_data.started));
					compare_field("paused", 32'(want.paused), 32'(out_data.paused));
					compare_field("playing", 32'(want.playing), 32'(out_data.playing));
					compare_field("underrun_total", want.underrun_total,
						out_data.underrun_total);
					compare_field("peak_fill", 32'(want.peak_fill), 32'(out_data.peak_fill));
				end
			end
			if (in_valid && !in_stall) begin
				fresh = pace_tick(in_data);
				play_decisions.push_back(fresh);
				ticks++;
				if (fresh.started)
					starts++;
				if (fresh.paused)
					pauses++;
				if (fresh.action == ACT_SILENCE)
					silences++;
			end
			pending = play_decisions.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench of the playout pacing controller: directed runs through warmup,
// play, silence, pause and closing ticks, then shaped random tick streams
// under a series of register settings, most with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
	import pbpc_pkg::*;

	localparam int STALL_LIMIT = 4000;   // cycles with no transfer at all
	localparam int HOLD_CYCLES = 300;    // long receiver hold-off
	localparam int PHASES      = 10;
	localparam int PHASE_TICKS = 108;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	in_t                        in_data = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	out_t                       out_data;

	int fails, pending, ticks, starts, pauses, silences;

	// stimulus-side view of the registers, used only to shape the levels
	cfg_t cur_cfg = '0;
	int   n_settings = 1;
	logic calm = 1'b0;       // no idling on either side
	logic hold_req = 1'b0;   // ask the receiver for one long hold-off
	logic hold_done = 1'b0;
	int   hold_cnt = 0;
	int   quiet_cycles = 0;

	always #10 clk = ~clk;

	playout_buffer_pacing_control_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	pbpc_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.fails     (fails),
		.pending   (pending),
		.ticks     (ticks),
		.starts    (starts),
		.pauses    (pauses),
		.silences  (silences)
	);

	// receiver: random stall, one long counted hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
		end
	end

	// watchdog: cycles in which neither channel completes a transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t  no transfer for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] sat16(input int v);
		if (v < 0)
			return 16'd0;
		if (v > 65535)
			return 16'hFFFF;
		return v[15:0];
	endfunction

	// offer one tick, maybe after an idle gap; returns at the edge of its transfer
	task automatic send_tick(input logic [15:0] level, input logic closing);
		logic took;
		if (!calm) begin
			while ($urandom_range(99) < 37) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= '{fill_level: level, closing: closing};
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
	endtask

	// sender pauses until every predicted result has been seen
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_t c);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_FRAME_MODE;
		cfg_wdata <= {15'd0, c.frame_mode};
		@(posedge clk);
		cfg_index <= CFG_WARMUP;
		cfg_wdata <= c.warmup_bytes;
		@(posedge clk);
		cfg_index <= CFG_LOW_WATER;
		cfg_wdata <= c.low_water_bytes;
		@(posedge clk);
		cfg_index <= CFG_GRACE;
		cfg_wdata <= {8'd0, c.grace_ticks};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		cur_cfg = c;
		n_settings++;
	endtask

	// random ticks in bursts: underrun runs, steady play, levels at the
	// thresholds, plain noise and the extremes, with some closing ticks
	task automatic play_random(input int budget);
		int sent, scene, burst, k, frame, warm, low_mark, pick;
		logic [15:0] level;
		logic closing;
		frame = cur_cfg.frame_mode ? 160 : 320;
		warm = (cur_cfg.warmup_bytes != 0) ? cur_cfg.warmup_bytes : frame * 40;
		low_mark = (cur_cfg.low_water_bytes != 0) ? cur_cfg.low_water_bytes : frame * 20;
		sent = 0;
		while (sent < budget) begin
			scene = $urandom_range(99);
			if (scene < 30) begin
				// short runs, or long enough to run out the grace period
				burst = $urandom_range(1) ? $urandom_range(8, 1)
					: cur_cfg.grace_ticks + $urandom_range(4, 1);
			end else if (scene < 60) begin
				burst = $urandom_range(16, 1);
			end else begin
				burst = $urandom_range(6, 1);
			end
			for (k = 0; k < burst; k++) begin
				if (scene < 30) begin
					level = 16'($urandom_range(frame - 1, 0));
				end else if (scene < 60) begin
					level = 16'($urandom_range(sat16(warm + frame * 8), frame));
				end else if (scene < 75) begin
					pick = $urandom_range(7);
					case (pick)
						0: level = sat16(warm - 1);
						1: level = sat16(warm);
						2: level = sat16(warm + 1);
						3: level = sat16(low_mark - 1);
						4: level = sat16(low_mark);
						5: level = sat16(low_mark + 1);
						6: level = sat16(frame - 1);
						default: level = sat16(frame);
					endcase
				end else if (scene < 90) begin
					level = 16'($urandom_range(16'hFFFF));
				end else begin
					level = $urandom_range(1) ? 16'hFFFF : 16'd0;
				end
				closing = ($urandom_range(99) < 6);
				if (closing && $urandom_range(1))
					level = 16'($urandom_range(16'hFFFF));
				send_tick(level, closing);
				sent++;
			end
		end
	endtask

	initial begin
		cfg_t c;
		int ph;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: 320-byte frames, warmup 12800, low water 6400, no grace
		send_tick(16'd0, 1'b0);        // idle, below warmup
		send_tick(16'hFFFF, 1'b1);     // closing tick must not move the peak
		send_tick(16'd12799, 1'b0);    // one byte short of warmup
		send_tick(16'd12800, 1'b0);    // start and first frame
		send_tick(16'd320, 1'b0);      // exactly one frame
		send_tick(16'd319, 1'b0);      // underrun with no grace: pause
		send_tick(16'hFFFF, 1'b0);     // restart at the top level
		send_tick(16'd6400, 1'b0);
		send_tick(16'd0, 1'b1);
		drain();

		// warmup below one frame: start and underrun on the same tick
		c = '{frame_mode: 1'b1, warmup_bytes: 16'd100, low_water_bytes: 16'd50,
			grace_ticks: 8'd2};
		write_cfg(c);
		send_tick(16'd99, 1'b0);
		send_tick(16'd100, 1'b0);      // start plus silence
		send_tick(16'd60, 1'b0);       // second grace tick
		send_tick(16'd10, 1'b0);       // past grace, below low water: pause
		send_tick(16'd100, 1'b0);
		send_tick(16'd160, 1'b0);      // one mu-law frame
		send_tick(16'd50, 1'b0);
		send_tick(16'd50, 1'b1);       // closing keeps the streak
		send_tick(16'd50, 1'b0);
		send_tick(16'd50, 1'b0);       // past grace at low water: stays active
		send_tick(16'd159, 1'b0);
		send_tick(16'd49, 1'b0);       // now below low water: pause
		send_tick(16'd0, 1'b0);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: c = '{frame_mode: 1'b1, warmup_bytes: 16'd0, low_water_bytes: 16'd0,
					grace_ticks: 8'd0};
				1: c = '{frame_mode: 1'b0, warmup_bytes: 16'hFFFF,
					low_water_bytes: 16'hFFFF, grace_ticks: 8'hFF};
				2: c = '{frame_mode: 1'b1, warmup_bytes: 16'd1, low_water_bytes: 16'd1,
					grace_ticks: 8'd5};
				3: c = '{frame_mode: 1'b0, warmup_bytes: 16'd0,
					low_water_bytes: 16'hFFFF, grace_ticks: 8'd0};
				4: c = '{frame_mode: 1'b0, warmup_bytes: 16'd319, low_water_bytes: 16'd0,
					grace_ticks: 8'd1};
				default: begin
					c.frame_mode = 1'($urandom_range(1));
					c.warmup_bytes = $urandom_range(1) ? 16'd0
						: 16'(($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
						: $urandom_range(4000));
					c.low_water_bytes = $urandom_range(1) ? 16'd0
						: 16'(($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
						: $urandom_range(2000));
					c.grace_ticks = 8'(($urandom_range(7) == 0) ? $urandom_range(8'hFF)
						: $urandom_range(12));
				end
			endcase
			write_cfg(c);
			calm <= (ph == 4);
			// block fills up and stalls its tick input while results are held off
			if (ph == 5)
				hold_req <= 1'b1;
			play_random(PHASE_TICKS);
			drain();
		end

		calm <= 1'b0;
		repeat (8) @(posedge clk);
		$display("covered %0d ticks under %0d register settings, defaults and extremes included",
			ticks, n_settings);
		$display("predicted %0d starts, %0d pauses for refill and %0d silence frames",
			starts, pauses, silences);
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/core/pbpc_pkg.sv
rtl/core/pbpc_step.sv
rtl/core/playout_buffer_pacing_control_core.sv
rtl/core/pbpc_checker.sv
tb/pbpc_checker.sv
tb/tb.sv
